// File: src/tgq_pkg.sv
// Shared types, constants and helpers for the text glyph quad generator.
`default_nettype none

package tgq_pkg;

  typedef struct packed {
    logic [7:0]         char_code;
    logic               first_of_text;
    logic signed [15:0] start_x;
    logic signed [15:0] start_y;
  } tgq_in_t;

  typedef struct packed {
    logic signed [19:0] pos_x;
    logic signed [19:0] pos_y;
    logic [15:0]        tex_u;
    logic [15:0]        tex_v;
    logic               last_vertex;
  } tgq_out_t;

  typedef enum logic [2:0] {
    REG_FIRST_CODE   = 3'd0,
    REG_TABLE_SIZE   = 3'd1,
    REG_GLYPH_WIDTH  = 3'd2,
    REG_GLYPH_HEIGHT = 3'd3,
    REG_SCALE_X      = 3'd4,
    REG_SCALE_Y      = 3'd5
  } tgq_reg_e;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 18;

  localparam logic [7:0]         RST_FIRST_CODE   = 8'd32;
  localparam logic [7:0]         RST_TABLE_SIZE   = 8'd96;
  localparam logic [7:0]         RST_GLYPH_WIDTH  = 8'd8;
  localparam logic [7:0]         RST_GLYPH_HEIGHT = 8'd16;
  localparam logic signed [17:0] RST_SCALE        = 18'sd0;

  localparam logic [7:0] CHAR_NUL     = 8'd0;
  localparam logic [7:0] CHAR_NEWLINE = 8'd10;
  localparam logic [7:0] CHAR_SPACE   = 8'd32;

  localparam logic [15:0] TEX_FULL = 16'hFFFF;
  localparam logic [15:0] TEX_ZERO = 16'h0000;

  localparam logic signed [19:0] Q_MIN   = 20'sh80000;
  localparam logic signed [19:0] Q_MAX   = 20'sh7FFFF;
  localparam logic signed [35:0] Q_MIN_W = -36'sd524288;
  localparam logic signed [35:0] Q_MAX_W = 36'sd524287;
  localparam logic [35:0]        ONE_W   = 36'd65536;

  localparam logic [2:0] VTX_FIRST = 3'd0;
  localparam logic [2:0] VTX_LAST  = 3'd5;

  typedef struct packed {
    logic       load;
    logic       mult;
    logic       start;
    logic       update;
    logic       emit;
    logic       finish;
    logic [2:0] vtx;
  } tgq_cmd_t;

  typedef struct packed {
    logic is_glyph;
    logic div_busy;
    logic out_free;
  } tgq_sts_t;

  function automatic logic signed [19:0] sat_q(input logic signed [35:0] v);
    logic signed [19:0] r;
    if (v < Q_MIN_W) begin
      r = Q_MIN;
    end else if (v > Q_MAX_W) begin
      r = Q_MAX;
    end else begin
      r = v[19:0];
    end
    return r;
  endfunction

  function automatic logic [35:0] ext20(input logic signed [19:0] v);
    return {{16{v[19]}}, v};
  endfunction

endpackage

`default_nettype wire

// File: src/tgq_divider.sv
// Restoring divider, one quotient bit per cycle, for texture coordinates.
`default_nettype none

module tgq_divider (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [23:0] numer,
  input  wire logic [7:0]  denom,
  output logic             busy,
  output logic [15:0]      quot
);

  logic        busy_r;
  logic [3:0]  cnt_r;
  logic [7:0]  rem_r;
  logic [7:0]  den_r;
  logic [15:0] quo_r;

  logic [8:0]  trial;
  logic [8:0]  diff;
  logic        ge;
  logic [7:0]  rem_nxt;
  logic [15:0] quo_nxt;

  // Numerator high byte is always below the divisor, so 16 steps suffice.
  assign trial   = {rem_r, quo_r[15]};
  assign diff    = trial - {1'b0, den_r};
  assign ge      = (trial >= {1'b0, den_r});
  assign rem_nxt = ge ? diff[7:0] : trial[7:0];
  assign quo_nxt = {quo_r[14:0], ge};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= 4'd0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= 4'd0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + 4'd1;
      if (cnt_r == 4'hF) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= numer[23:16];
      quo_r <= numer[15:0];
      den_r <= denom;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  assign busy = busy_r;
  assign quot = quo_r;

  a_start_busy : assert property (@(posedge clk) disable iff (!rst_n)
    start |=> busy_r) else $error("divider did not start");
  a_div_length : assert property (@(posedge clk) disable iff (!rst_n)
    start |-> ##16 busy_r ##1 !busy_r) else $error("divider length wrong");

endmodule

`default_nettype wire

// File: src/tgq_datapath.sv
// Configuration registers, cursor state, fixed-point arithmetic and vertex output.
`default_nettype none

module tgq_datapath (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             cfg_we,
  input  wire logic [tgq_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [tgq_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  wire tgq_pkg::tgq_in_t                 in_data,
  output tgq_pkg::tgq_out_t                     out_data,
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  input  wire tgq_pkg::tgq_cmd_t                cmd,
  output tgq_pkg::tgq_sts_t                     sts
);
  import tgq_pkg::*;

  typedef enum logic [2:0] {
    CLS_SKIP,
    CLS_END,
    CLS_NEWLINE,
    CLS_ADVANCE,
    CLS_GLYPH
  } cls_t;

  logic [7:0]         first_code_r;
  logic [7:0]         table_size_r;
  logic [7:0]         glyph_width_r;
  logic [7:0]         glyph_height_r;
  logic signed [17:0] scale_x_r;
  logic signed [17:0] scale_y_r;

  logic signed [19:0] cursor_x_r;
  logic signed [19:0] cursor_y_r;
  logic signed [19:0] left_border_r;
  logic               text_ended_r;

  logic signed [19:0] cell_w_r;
  logic signed [19:0] cell_h_r;
  tgq_in_t            item_r;
  logic signed [33:0] mul_x_r;
  logic signed [33:0] mul_y_r;
  logic signed [19:0] right_r;
  logic signed [19:0] bottom_r;
  logic               out_valid_r;
  tgq_out_t           out_r;

  logic signed [26:0] cw_prod;
  logic signed [26:0] ch_prod;
  logic signed [19:0] start_x_sat;
  logic signed [19:0] start_y_sat;
  logic signed [19:0] right_nxt;
  logic signed [19:0] bottom_nxt;
  logic [7:0]         k_idx;
  logic [7:0]         k_next;
  logic [23:0]        numer_left;
  logic [23:0]        numer_right;
  logic               div_start;
  logic               busy_left;
  logic               busy_right;
  logic [15:0]        u_left;
  logic [15:0]        u_right;
  cls_t               cls;
  tgq_out_t           vtx;

  assign cw_prod = $signed({1'b0, glyph_width_r}) * scale_x_r;
  assign ch_prod = $signed({1'b0, glyph_height_r}) * scale_y_r;

  assign start_x_sat = sat_q({{2{mul_x_r[33]}}, mul_x_r} - ONE_W);
  assign start_y_sat = sat_q({{2{mul_y_r[33]}}, mul_y_r} + ONE_W);
  assign right_nxt   = sat_q(ext20(cursor_x_r) + ext20(cell_w_r));
  assign bottom_nxt  = sat_q(ext20(cursor_y_r) + ext20(cell_h_r));

  assign k_idx       = item_r.char_code - first_code_r;
  assign k_next      = k_idx + 8'd1;
  assign numer_left  = {k_idx, 16'h0000} - {16'h0000, k_idx};
  assign numer_right = {k_next, 16'h0000} - {16'h0000, k_next};

  always_comb begin
    priority if (text_ended_r) begin
      cls = CLS_SKIP;
    end else if (item_r.char_code == CHAR_NUL) begin
      cls = CLS_END;
    end else if (item_r.char_code == CHAR_NEWLINE) begin
      cls = CLS_NEWLINE;
    end else if (item_r.char_code == CHAR_SPACE || item_r.char_code < first_code_r ||
                 k_idx >= table_size_r) begin
      cls = CLS_ADVANCE;
    end else begin
      cls = CLS_GLYPH;
    end
  end

  assign div_start = cmd.update && (cls == CLS_GLYPH);

  tgq_divider u_div_left (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .numer (numer_left),
    .denom (table_size_r),
    .busy  (busy_left),
    .quot  (u_left)
  );

  tgq_divider u_div_right (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .numer (numer_right),
    .denom (table_size_r),
    .busy  (busy_right),
    .quot  (u_right)
  );

  // Vertex order: LT, RT, LB, RT, RB, LB.
  always_comb begin
    vtx.last_vertex = 1'b0;
    unique case (cmd.vtx)
      3'd0: begin
        vtx.pos_x = cursor_x_r; vtx.pos_y = cursor_y_r;
        vtx.tex_u = u_left;     vtx.tex_v = TEX_ZERO;
      end
      3'd1, 3'd3: begin
        vtx.pos_x = right_r;    vtx.pos_y = cursor_y_r;
        vtx.tex_u = u_right;    vtx.tex_v = TEX_ZERO;
      end
      3'd2: begin
        vtx.pos_x = cursor_x_r; vtx.pos_y = bottom_r;
        vtx.tex_u = u_left;     vtx.tex_v = TEX_FULL;
      end
      3'd4: begin
        vtx.pos_x = right_r;    vtx.pos_y = bottom_r;
        vtx.tex_u = u_right;    vtx.tex_v = TEX_FULL;
      end
      default: begin
        vtx.pos_x = cursor_x_r; vtx.pos_y = bottom_r;
        vtx.tex_u = u_left;     vtx.tex_v = TEX_FULL;
        vtx.last_vertex = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_code_r   <= RST_FIRST_CODE;
      table_size_r   <= RST_TABLE_SIZE;
      glyph_width_r  <= RST_GLYPH_WIDTH;
      glyph_height_r <= RST_GLYPH_HEIGHT;
      scale_x_r      <= RST_SCALE;
      scale_y_r      <= RST_SCALE;
      cursor_x_r     <= '0;
      cursor_y_r     <= '0;
      left_border_r  <= '0;
      text_ended_r   <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_FIRST_CODE:   first_code_r   <= cfg_data[7:0];
          REG_TABLE_SIZE:   table_size_r   <= cfg_data[7:0];
          REG_GLYPH_WIDTH:  glyph_width_r  <= cfg_data[7:0];
          REG_GLYPH_HEIGHT: glyph_height_r <= cfg_data[7:0];
          REG_SCALE_X:      scale_x_r      <= cfg_data;
          REG_SCALE_Y:      scale_y_r      <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.start && item_r.first_of_text) begin
        cursor_x_r    <= start_x_sat;
        cursor_y_r    <= start_y_sat;
        left_border_r <= start_x_sat;
        text_ended_r  <= 1'b0;
      end
      if (cmd.update) begin
        unique case (cls)
          CLS_END:     text_ended_r <= 1'b1;
          CLS_NEWLINE: begin
            cursor_x_r <= left_border_r;
            cursor_y_r <= bottom_nxt;
          end
          CLS_ADVANCE: cursor_x_r <= right_nxt;
          default: ;
        endcase
      end
      if (cmd.finish) begin
        cursor_x_r <= right_r;
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    cell_w_r <= sat_q({{9{cw_prod[26]}}, cw_prod});
    cell_h_r <= sat_q({{9{ch_prod[26]}}, ch_prod});
    if (cmd.load) begin
      item_r <= in_data;
    end
    if (cmd.mult) begin
      mul_x_r <= item_r.start_x * scale_x_r;
      mul_y_r <= item_r.start_y * scale_y_r;
    end
    if (div_start) begin
      right_r  <= right_nxt;
      bottom_r <= bottom_nxt;
    end
    if (cmd.emit) begin
      out_r <= vtx;
    end
  end

  assign sts.is_glyph = (cls == CLS_GLYPH);
  assign sts.div_busy = busy_left || busy_right;
  assign sts.out_free = !out_valid_r || !out_stall;

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_emit_free : assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> (!out_valid_r || !out_stall)) else $error("vertex overwrote pending request");
  a_last_flag : assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit && cmd.vtx == VTX_LAST) |=> (out_valid_r && out_r.last_vertex))
    else $error("sixth vertex lacks last flag");

endmodule

`default_nettype wire

// File: src/tgq_ctrl.sv
// Controller state machine sequencing load, start position, layout, divide and emit.
`default_nettype none

module tgq_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire tgq_pkg::tgq_sts_t sts,
  output tgq_pkg::tgq_cmd_t      cmd
);
  import tgq_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MULT,
    ST_START,
    ST_CLASS,
    ST_DIVIDE,
    ST_EMIT
  } state_t;

  state_t     state_r;
  logic [2:0] vtx_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      vtx_r   <= VTX_FIRST;
    end else begin
      unique case (state_r)
        ST_IDLE:  if (in_valid) state_r <= ST_MULT;
        ST_MULT:  state_r <= ST_START;
        ST_START: state_r <= ST_CLASS;
        ST_CLASS: state_r <= sts.is_glyph ? ST_DIVIDE : ST_IDLE;
        ST_DIVIDE: begin
          if (!sts.div_busy) begin
            state_r <= ST_EMIT;
            vtx_r   <= VTX_FIRST;
          end
        end
        ST_EMIT: begin
          if (sts.out_free) begin
            vtx_r <= vtx_r + 3'd1;
            if (vtx_r == VTX_LAST) begin
              state_r <= ST_IDLE;
            end
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign in_stall   = (state_r != ST_IDLE);
  assign cmd.load   = (state_r == ST_IDLE) && in_valid;
  assign cmd.mult   = (state_r == ST_MULT);
  assign cmd.start  = (state_r == ST_START);
  assign cmd.update = (state_r == ST_CLASS);
  assign cmd.emit   = (state_r == ST_EMIT) && sts.out_free;
  assign cmd.finish = cmd.emit && (vtx_r == VTX_LAST);
  assign cmd.vtx    = vtx_r;

  a_emit_after_div : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT) |-> !sts.div_busy) else $error("emit while dividing");
  a_emit_from_first : assert property (@(posedge clk) disable iff (!rst_n)
    $rose(state_r == ST_EMIT) |-> (vtx_r == VTX_FIRST)) else $error("quad starts mid-way");

endmodule

`default_nettype wire

// File: src/text_glyph_quad_generator_top.sv
// Top level of the text glyph quad generator.
//
//   port group   direction  role
//   in_*         request in one text byte with optional start position
//   out_*        request out one vertex (six per printed glyph)
//   cfg_*        write      font table, cell size and scale registers
//
// A NUL, newline, space or non-table byte goes through load, start position and layout.
// A printed glyph then also runs the two parallel bit-serial dividers for the texture
// coordinates and emits its vertices.
// Output stalls lengthen the emit phase.
// Reset (rst_n low, synchronous) restores register defaults and clears the cursor.
`default_nettype none

module text_glyph_quad_generator_top (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire tgq_pkg::tgq_in_t               in_data,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output tgq_pkg::tgq_out_t                   out_data,
  input  wire logic                           cfg_we,
  input  wire logic [tgq_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [tgq_pkg::CFG_DATA_W-1:0] cfg_data
);
  import tgq_pkg::*;

  tgq_cmd_t cmd;
  tgq_sts_t sts;

  tgq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  tgq_datapath u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .out_data  (out_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule

`default_nettype wire

// File: test/tgq_vertex_checker.sv
// Checker that lays out text bytes itself and compares the block's vertex stream.
module tgq_vertex_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic                           in_stall,
  input  tgq_pkg::tgq_in_t               in_data,
  input  logic                           out_valid,
  input  logic                           out_stall,
  input  tgq_pkg::tgq_out_t              out_data,
  input  logic                           cfg_we,
  input  logic [tgq_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tgq_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                             fail_count,
  output int                             pending
);
  import tgq_pkg::*;

  logic [7:0]         first_code;
  logic [7:0]         table_size;
  logic [7:0]         glyph_w;
  logic [7:0]         glyph_h;
  logic signed [17:0] scale_x;
  logic signed [17:0] scale_y;

  logic signed [19:0] cur_x;
  logic signed [19:0] cur_y;
  logic signed [19:0] line_left;
  bit                 text_done;

  tgq_out_t vertices_due[$];
  tgq_out_t want;
  int       mismatches = 0;

  function automatic logic signed [19:0] clamp_q(input longint v);
    if (v < longint'(Q_MIN)) return Q_MIN;
    if (v > longint'(Q_MAX)) return Q_MAX;
    return v[19:0];
  endfunction

  function automatic void push_vertex(input logic signed [19:0] x, input logic signed [19:0] y,
                                      input logic [15:0] u, input logic [15:0] v,
                                      input logic last);
    tgq_out_t vtx;
    vtx.pos_x       = x;
    vtx.pos_y       = y;
    vtx.tex_u       = u;
    vtx.tex_v       = v;
    vtx.last_vertex = last;
    vertices_due.push_back(vtx);
  endfunction

  function automatic void lay_out_byte(input tgq_in_t b);
    logic signed [19:0] cell_w;
    logic signed [19:0] cell_h;
    logic signed [19:0] right;
    logic signed [19:0] bottom;
    logic [15:0]        u_l;
    logic [15:0]        u_r;
    int                 k;
    cell_w = clamp_q(longint'(glyph_w) * longint'(scale_x));
    cell_h = clamp_q(longint'(glyph_h) * longint'(scale_y));
    if (b.first_of_text) begin
      cur_x     = clamp_q(longint'($signed(b.start_x)) * longint'(scale_x) - 65536);
      cur_y     = clamp_q(longint'($signed(b.start_y)) * longint'(scale_y) + 65536);
      line_left = cur_x;
      text_done = 1'b0;
    end
    if (text_done) return;
    k = int'(b.char_code) - int'(first_code);
    if (b.char_code == CHAR_NUL) begin
      text_done = 1'b1;
    end else if (b.char_code == CHAR_NEWLINE) begin
      cur_x = line_left;
      cur_y = clamp_q(longint'(cur_y) + longint'(cell_h));
    end else if (b.char_code == CHAR_SPACE || k < 0 || k >= int'(table_size)) begin
      cur_x = clamp_q(longint'(cur_x) + longint'(cell_w));
    end else begin
      u_l    = 16'((65535 * k) / int'(table_size));
      u_r    = 16'((65535 * (k + 1)) / int'(table_size));
      right  = clamp_q(longint'(cur_x) + longint'(cell_w));
      bottom = clamp_q(longint'(cur_y) + longint'(cell_h));
      // two triangles: LT RT LB, RT RB LB
      push_vertex(cur_x, cur_y,  u_l, TEX_ZERO, 1'b0);
      push_vertex(right, cur_y,  u_r, TEX_ZERO, 1'b0);
      push_vertex(cur_x, bottom, u_l, TEX_FULL, 1'b0);
      push_vertex(right, cur_y,  u_r, TEX_ZERO, 1'b0);
      push_vertex(right, bottom, u_r, TEX_FULL, 1'b0);
      push_vertex(cur_x, bottom, u_l, TEX_FULL, 1'b1);
      cur_x = right;
    end
  endfunction

  function automatic void compare_field(input string name, input logic [19:0] want_v,
                                        input logic [19:0] got_v);
    if (got_v !== want_v) begin
      mismatches++;
      $display("%0t: %s expected %h actual %h", $time, name, want_v, got_v);
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      first_code = RST_FIRST_CODE;
      table_size = RST_TABLE_SIZE;
      glyph_w    = RST_GLYPH_WIDTH;
      glyph_h    = RST_GLYPH_HEIGHT;
      scale_x    = RST_SCALE;
      scale_y    = RST_SCALE;
      cur_x      = '0;
      cur_y      = '0;
      line_left  = '0;
      text_done  = 1'b0;
      vertices_due.delete();
    end else begin
      if (cfg_we) begin
        case (tgq_reg_e'(cfg_index))
          REG_FIRST_CODE:   first_code = cfg_data[7:0];
          REG_TABLE_SIZE:   table_size = cfg_data[7:0];
          REG_GLYPH_WIDTH:  glyph_w    = cfg_data[7:0];
          REG_GLYPH_HEIGHT: glyph_h    = cfg_data[7:0];
          REG_SCALE_X:      scale_x    = $signed(cfg_data);
          REG_SCALE_Y:      scale_y    = $signed(cfg_data);
          default: ;
        endcase
      end
      if (in_valid && !in_stall) lay_out_byte(in_data);
      if (out_valid && !out_stall) begin
        if (vertices_due.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected vertex x %h y %h u %h v %h last %b", $time,
                   out_data.pos_x, out_data.pos_y, out_data.tex_u, out_data.tex_v,
                   out_data.last_vertex);
        end else begin
          want = vertices_due.pop_front();
          compare_field("pos_x", want.pos_x, out_data.pos_x);
          compare_field("pos_y", want.pos_y, out_data.pos_y);
          compare_field("tex_u", 20'(want.tex_u), 20'(out_data.tex_u));
          compare_field("tex_v", 20'(want.tex_v), 20'(out_data.tex_v));
          compare_field("last_vertex", 20'(want.last_vertex), 20'(out_data.last_vertex));
        end
      end
    end
    fail_count <= mismatches;
    pending    <= vertices_due.size();
  end

endmodule

// File: test/tb.sv
// Testbench top: drives text bytes and register writes, and gives the verdict.
module tb;
  import tgq_pkg::*;

  localparam int STUCK_LIMIT = 3000;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_stall;
  tgq_in_t               in_data   = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  tgq_out_t              out_data;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  int         fail_count;
  int         pending;
  int         stuck_cycles = 0;
  int         byte_count   = 0;
  bit         steady       = 1'b0;
  bit         stim_ended   = 1'b0;
  logic [7:0] cur_first    = RST_FIRST_CODE;
  logic [7:0] cur_size     = RST_TABLE_SIZE;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  text_glyph_quad_generator_top DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  tgq_vertex_checker u_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always @(posedge clk) begin
    out_stall <= rst_n && !steady && ($urandom_range(99) < 18);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      stuck_cycles <= 0;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
    if (stuck_cycles >= STUCK_LIMIT) begin
      $display("[text_glyph_quad_generator_top] ERROR");
      $finish;
    end
  end

  function automatic tgq_in_t text_byte(input logic [7:0] code, input logic first,
                                        input logic [15:0] sx, input logic [15:0] sy);
    tgq_in_t b;
    b.char_code     = code;
    b.first_of_text = first;
    b.start_x       = sx;
    b.start_y       = sy;
    return b;
  endfunction

  task automatic send_byte(input tgq_in_t b);
    while (!steady && $urandom_range(99) < 18) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (b.first_of_text) stim_ended = 1'b0;
    if (!stim_ended) byte_count++;
    if (b.char_code == CHAR_NUL) stim_ended = 1'b1;
  endtask

  // hold off new requests until every vertex is out
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic configure(input logic [7:0] fc, input logic [7:0] ts, input logic [7:0] gw,
                           input logic [7:0] gh, input logic [17:0] sx, input logic [17:0] sy);
    tgq_reg_e    order[6];
    logic [17:0] vals[6];
    order = '{REG_FIRST_CODE, REG_TABLE_SIZE, REG_GLYPH_WIDTH, REG_GLYPH_HEIGHT,
              REG_SCALE_X, REG_SCALE_Y};
    vals  = '{{10'd0, fc}, {10'd0, ts}, {10'd0, gw}, {10'd0, gh}, sx, sy};
    drain();
    // a byte that makes no vertex may still be in flight
    repeat (8) @(posedge clk);
    for (int i = 0; i < 6; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= order[i];
      cfg_data  <= vals[i];
      @(posedge clk);
    end
    cfg_we    <= 1'b0;
    cur_first = fc;
    cur_size  = ts;
  endtask

  function automatic logic [17:0] rand_scale(input bit full);
    if (full) return 18'($urandom);
    return 18'(int'($urandom_range(0, 800)) - 400);
  endfunction

  function automatic logic [7:0] pick_code();
    int r;
    int span;
    r    = $urandom_range(99);
    span = (int'(cur_first) + int'(cur_size) > 256) ? 256 - int'(cur_first) : int'(cur_size);
    if (r < 65 && span > 0) return 8'(int'(cur_first) + int'($urandom_range(0, span - 1)));
    if (r < 75) return CHAR_SPACE;
    if (r < 84) return CHAR_NEWLINE;
    if (r < 88) return CHAR_NUL;
    return 8'($urandom);
  endfunction

  task automatic run_text();
    int      len;
    tgq_in_t b;
    len = $urandom_range(1, 20);
    for (int i = 0; i < len; i++) begin
      b = text_byte(pick_code(), 1'b0, 16'($urandom), 16'($urandom));
      if (i == 0 && $urandom_range(19) != 0) begin
        b.first_of_text = 1'b1;
        if ($urandom_range(1) == 0) begin
          b.start_x = 16'(int'($urandom_range(0, 1000)) - 500);
          b.start_y = 16'(int'($urandom_range(0, 1000)) - 500);
        end
      end else if ($urandom_range(49) == 0) begin
        b.first_of_text = 1'b1;
      end
      send_byte(b);
    end
    if ($urandom_range(19) == 0) drain();
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // layout from the reset cursor, no start position given
    send_byte(text_byte("A", 1'b0, 16'h0000, 16'h0000));
    send_byte(text_byte(8'd126, 1'b0, 16'hFFFF, 16'hFFFF));

    configure(8'd32, 8'd96, 8'd8, 8'd16, 18'(205), 18'(-273));
    send_byte(text_byte("H", 1'b1, 16'h0000, 16'h0000));
    send_byte(text_byte("i", 1'b0, 16'h0000, 16'h0000));
    send_byte(text_byte(CHAR_SPACE, 1'b0, 16'h0000, 16'h0000));
    send_byte(text_byte(8'd33, 1'b0, 16'h0000, 16'h0000));
    send_byte(text_byte(8'd127, 1'b0, 16'h0000, 16'h0000));
    send_byte(text_byte(8'd128, 1'b0, 16'h0000, 16'h0000));
    send_byte(text_byte(8'd31, 1'b0, 16'h0000, 16'h0000));
    send_byte(text_byte(CHAR_NEWLINE, 1'b0, 16'h0000, 16'h0000));
    send_byte(text_byte("~", 1'b0, 16'h0000, 16'h0000));
    send_byte(text_byte(CHAR_NUL, 1'b0, 16'h0000, 16'h0000));
    send_byte(text_byte("X", 1'b0, 16'h0000, 16'h0000));
    send_byte(text_byte(CHAR_NEWLINE, 1'b0, 16'h0000, 16'h0000));
    send_byte(text_byte("Q", 1'b1, 16'h7FFF, 16'h8000));
    send_byte(text_byte(8'd255, 1'b1, 16'h8000, 16'h7FFF));
    send_byte(text_byte("W", 1'b0, 16'h0000, 16'h0000));

    configure(8'd255, 8'd255, 8'd255, 8'd255, 18'h1FFFF, 18'h20000);
    send_byte(text_byte(8'd255, 1'b1, 16'h7FFF, 16'h7FFF));
    send_byte(text_byte(8'd254, 1'b0, 16'h0000, 16'h0000));
    send_byte(text_byte(CHAR_NEWLINE, 1'b0, 16'h0000, 16'h0000));
    send_byte(text_byte(8'd255, 1'b0, 16'h0000, 16'h0000));

    configure(8'd0, 8'd255, 8'd1, 8'd1, 18'h20000, 18'h1FFFF);
    send_byte(text_byte(8'd254, 1'b1, 16'h8000, 16'h8000));
    send_byte(text_byte(8'd1, 1'b0, 16'h0000, 16'h0000));
    send_byte(text_byte(CHAR_SPACE, 1'b0, 16'h0000, 16'h0000));
    send_byte(text_byte(CHAR_NEWLINE, 1'b0, 16'h0000, 16'h0000));

    // empty font table: everything only advances
    configure(8'd32, 8'd0, 8'd8, 8'd16, 18'(205), 18'(-273));
    send_byte(text_byte("A", 1'b1, 16'h0010, 16'h0010));

    byte_count = 0;
    for (int p = 0; p < 5; p++) begin
      case (p)
        0: configure(8'd32, 8'd96, 8'd8, 8'd16, rand_scale(1'b0), rand_scale(1'b0));
        1: configure(8'($urandom), 8'($urandom_range(1, 255)), 8'($urandom_range(1, 255)),
                     8'($urandom_range(1, 255)), rand_scale(1'b0), rand_scale(1'b0));
        2: configure(8'($urandom_range(0, 64)), 8'($urandom_range(1, 255)),
                     8'($urandom_range(1, 255)), 8'($urandom_range(1, 255)),
                     rand_scale(1'b1), rand_scale(1'b1));
        3: configure(8'd0, 8'd255, 8'd255, 8'd255, 18'h1FFFF, 18'h20000);
        default: configure(8'($urandom_range(33, 200)), 8'd1, 8'd1, 8'd1,
                           18'h20000, 18'h1FFFF);
      endcase
      steady = (p == 2);
      while (byte_count < (p + 1) * 100) run_text();
    end
    steady = 1'b0;

    drain();
    repeat (40) @(posedge clk);
    if (pending != 0) $display("%0t: %0d vertices never arrived", $time, pending);
    if (fail_count == 0 && pending == 0) begin
      $display("[text_glyph_quad_generator_top] OK");
    end else begin
      $display("[text_glyph_quad_generator_top] ERROR");
    end
    $finish;
  end

endmodule

// File: files.f
src/tgq_pkg.sv
src/tgq_divider.sv
src/tgq_datapath.sv
src/tgq_ctrl.sv
src/text_glyph_quad_generator_top.sv
test/tgq_vertex_checker.sv
test/tb.sv
